// ===== rtl/wscc_pkg.sv =====
package wscc_pkg;

  localparam int unsigned SEG_W          = 16;
  localparam int unsigned WIN_W          = 6;
  localparam int unsigned MARKS          = 32;
  localparam int unsigned IDX_W          = 5;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned DEF_MAX_WINDOW = 32;

  localparam logic [SEG_W-1:0] LAST_SEG_RESET = 16'd1;
  localparam logic [WIN_W-1:0] THR_RESET      = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SEG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR = 1'b1;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_FIN_ACK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SEND       = 2'd0,
    KIND_RESEND     = 2'd1,
    KIND_FIN        = 2'd2,
    KIND_FIN_RESEND = 2'd3
  } kind_e;

  typedef struct packed {
    logic latch_in;
    logic idx_clear;
    logic idx_inc;
    logic clear_marks;
    logic mark;
    logic advance;
    logic timeout_apply;
    logic set_awaiting;
    logic finish;
    logic send_emit;
    logic resend;
    logic fin_emit;
    logic fin_resend;
  } wscc_ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic is_idle;
    logic awaiting;
    logic done;
    logic highest_nz;
    logic ack_in_win;
    logic window_full;
    logic all_sent;
    logic scan_stop;
    logic send_last;
    logic out_free;
  } wscc_stat_t;

endpackage

// ===== rtl/wscc_ctrl.sv =====
module wscc_ctrl import wscc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  wscc_stat_t stat_i,
  output wscc_ctrl_t ctrl_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_SEND   = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   resend_q, resend_d;
  logic   fin_resend_q, fin_resend_d;

  always_comb begin
    state_d      = state_q;
    resend_d     = resend_q;
    fin_resend_d = fin_resend_q;
    ctrl_o       = '0;
    in_stall_o   = 1'b1;
    ctrl_o.resend     = resend_q;
    ctrl_o.fin_resend = fin_resend_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.latch_in = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        ctrl_o.idx_clear = 1'b1;
        unique case (stat_i.cmd)
          CMD_START: begin
            if (stat_i.is_idle) begin
              ctrl_o.clear_marks = 1'b1;
              resend_d           = 1'b0;
              state_d            = S_SEND;
            end
          end
          CMD_ACK: begin
            if (!stat_i.awaiting && !stat_i.done && stat_i.ack_in_win) begin
              ctrl_o.mark = 1'b1;
              state_d     = S_CHECK;
            end
          end
          CMD_TIMEOUT: begin
            if (stat_i.done) begin
              state_d = S_IDLE;
            end else if (stat_i.awaiting) begin
              fin_resend_d = 1'b1;
              state_d      = S_FIN;
            end else if (stat_i.highest_nz) begin
              state_d = S_SCAN;
            end
          end
          CMD_FIN_ACK: begin
            if (stat_i.awaiting) begin
              ctrl_o.finish = 1'b1;
            end
          end
        endcase
      end
      S_CHECK: begin
        state_d = S_IDLE;
        if (stat_i.window_full) begin
          ctrl_o.advance   = 1'b1;
          ctrl_o.idx_clear = 1'b1;
          if (stat_i.all_sent) begin
            ctrl_o.set_awaiting = 1'b1;
            fin_resend_d        = 1'b0;
            state_d             = S_FIN;
          end else begin
            resend_d = 1'b0;
            state_d  = S_SEND;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.scan_stop) begin
          ctrl_o.timeout_apply = 1'b1;
          ctrl_o.idx_clear     = 1'b1;
          resend_d             = 1'b1;
          state_d              = S_SEND;
        end else begin
          ctrl_o.idx_inc = 1'b1;
        end
      end
      S_SEND: begin
        if (stat_i.out_free) begin
          ctrl_o.send_emit = 1'b1;
          if (stat_i.send_last) begin
            ctrl_o.idx_clear = 1'b1;
            state_d          = S_IDLE;
          end else begin
            ctrl_o.idx_inc = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.fin_emit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      resend_q     <= 1'b0;
      fin_resend_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      resend_q     <= resend_d;
      fin_resend_q <= fin_resend_d;
    end
  end

endmodule

// ===== rtl/wscc_datapath.sv =====
module wscc_datapath import wscc_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           cmd_i,
  input  logic [SEG_W-1:0]     ack_id_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SEG_W-1:0]     cfg_data_i,
  input  logic                 out_stall_i,
  input  wscc_ctrl_t           ctrl_i,
  output wscc_stat_t           stat_o,
  output logic                 out_valid_o,
  output logic [1:0]           kind_o,
  output logic [SEG_W-1:0]     segment_id_o,
  output logic [WIN_W-1:0]     window_size_o,
  output logic [WIN_W-1:0]     threshold_o,
  output logic                 last_o
);

  localparam int unsigned WIN_CAP = (MAX_WINDOW < MARKS) ? MAX_WINDOW : MARKS;
  localparam logic [WIN_W:0] WIN_CAP_C = (WIN_W+1)'(WIN_CAP);

  cmd_e             cmd_q;
  logic [SEG_W-1:0] ack_q;
  logic [SEG_W-1:0] base_q;
  logic [WIN_W-1:0] win_q;
  logic [WIN_W-1:0] limit_q;
  logic [MARKS-1:0] marks_q;
  logic [WIN_W-1:0] total_q;
  logic [SEG_W-1:0] highest_q;
  logic             all_sent_q;
  logic             awaiting_q;
  logic             done_q;
  logic [SEG_W-1:0] last_seg_q;
  logic [WIN_W-1:0] idx_q;
  logic             out_valid_q;
  kind_e            kind_q;
  logic [SEG_W-1:0] seg_q;
  logic [WIN_W-1:0] win_out_q;
  logic [WIN_W-1:0] thr_out_q;
  logic             last_q;

  logic [SEG_W-1:0] diff;
  logic [SEG_W-1:0] diff_m1;
  logic [IDX_W-1:0] mark_k;
  logic [SEG_W-1:0] seg_id;
  logic             is_final;
  logic [WIN_W-1:0] idx_p1;
  logic [WIN_W:0]   grow_raw;
  logic [WIN_W-1:0] win_grow;
  logic [WIN_W-1:0] half_win;
  logic             is_idle;
  logic             out_free;

  assign diff     = ack_q - base_q;
  assign diff_m1  = diff - 16'd1;
  assign mark_k   = diff_m1[IDX_W-1:0];
  assign seg_id   = base_q + {{(SEG_W-WIN_W){1'b0}}, idx_q} + 16'd1;
  assign is_final = (seg_id >= last_seg_q);
  assign idx_p1   = idx_q + 6'd1;
  assign is_idle  = (highest_q == '0) && !all_sent_q && !awaiting_q && !done_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (win_q < limit_q) begin
      grow_raw = {win_q, 1'b0};
    end else begin
      grow_raw = {1'b0, win_q} + 7'd1;
    end
    if (grow_raw > WIN_CAP_C) begin
      grow_raw = WIN_CAP_C;
    end
    win_grow = grow_raw[WIN_W-1:0];
    half_win = win_q >> 1;
    if (half_win == '0) begin
      half_win = 6'd1;
    end
  end

  always_comb begin
    stat_o             = '0;
    stat_o.cmd         = cmd_q;
    stat_o.is_idle     = is_idle;
    stat_o.awaiting    = awaiting_q;
    stat_o.done        = done_q;
    stat_o.highest_nz  = (highest_q != '0);
    stat_o.ack_in_win  = (ack_q > base_q) && (diff <= {{(SEG_W-WIN_W){1'b0}}, win_q});
    stat_o.window_full = (total_q >= win_q);
    stat_o.all_sent    = all_sent_q;
    stat_o.scan_stop   = (idx_q == win_q) || !marks_q[idx_q[IDX_W-1:0]];
    stat_o.send_last   = is_final || (idx_p1 == win_q);
    stat_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      cmd_q <= cmd_e'(cmd_i);
      ack_q <= ack_id_i;
    end
    if (ctrl_i.send_emit) begin
      kind_q    <= (ctrl_i.resend || seg_id <= highest_q) ? KIND_RESEND : KIND_SEND;
      seg_q     <= seg_id;
      win_out_q <= is_final ? idx_p1 : win_q;
      thr_out_q <= limit_q;
      last_q    <= stat_o.send_last;
    end else if (ctrl_i.fin_emit) begin
      kind_q    <= ctrl_i.fin_resend ? KIND_FIN_RESEND : KIND_FIN;
      seg_q     <= '0;
      win_out_q <= win_q;
      thr_out_q <= limit_q;
      last_q    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      win_q       <= 6'd1;
      limit_q     <= THR_RESET;
      marks_q     <= '0;
      total_q     <= '0;
      highest_q   <= '0;
      all_sent_q  <= 1'b0;
      awaiting_q  <= 1'b0;
      done_q      <= 1'b0;
      last_seg_q  <= LAST_SEG_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LAST_SEG: last_seg_q <= cfg_data_i;
          CFG_INIT_THR: begin
            if (is_idle) begin
              limit_q <= cfg_data_i[WIN_W-1:0];
            end
          end
          default: ;
        endcase
      end

      if (ctrl_i.idx_clear) begin
        idx_q <= '0;
      end else if (ctrl_i.idx_inc) begin
        idx_q <= idx_p1;
      end

      if (ctrl_i.clear_marks || ctrl_i.advance || ctrl_i.timeout_apply) begin
        marks_q <= '0;
        total_q <= '0;
      end else if (ctrl_i.mark && !marks_q[mark_k]) begin
        marks_q[mark_k] <= 1'b1;
        total_q         <= total_q + 6'd1;
      end

      if (ctrl_i.advance) begin
        base_q <= base_q + {{(SEG_W-WIN_W){1'b0}}, win_q};
        win_q  <= win_grow;
      end

      if (ctrl_i.timeout_apply) begin
        base_q     <= base_q + {{(SEG_W-WIN_W){1'b0}}, idx_q};
        limit_q    <= half_win;
        win_q      <= 6'd1;
        all_sent_q <= 1'b0;
      end

      if (ctrl_i.send_emit) begin
        if (is_final) begin
          all_sent_q <= 1'b1;
          win_q      <= idx_p1;
        end
        if (seg_id > highest_q) begin
          highest_q <= seg_id;
        end
      end

      if (ctrl_i.set_awaiting) begin
        awaiting_q <= 1'b1;
      end
      if (ctrl_i.finish) begin
        awaiting_q <= 1'b0;
        done_q     <= 1'b1;
      end

      if (ctrl_i.send_emit || ctrl_i.fin_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign segment_id_o  = seg_q;
  assign window_size_o = win_out_q;
  assign threshold_o   = thr_out_q;
  assign last_o        = last_q;

endmodule

// ===== rtl/windowed_sender_congestion_control_unit.sv =====
// Channel   Direction  Handshake            Payload
// event     in         in_valid_i/in_stall_o   cmd_i, ack_id_i
// order     out        out_valid_o/out_stall_i kind_o, segment_id_o, window_size_o,
//                                              threshold_o, last_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An event request is latched and then decoded; an ack that completes a window then passes a check state.
// Send orders then follow one after another, each waiting while the output is stalled.
// A timeout first scans the ack marks one per cycle, then resends one.
// Reset is asynchronous and needs no clearing pass; the config port is always ready.
// Orders wait in an output register while stalled, and the next event request is taken
// as soon as the last order of a run is registered.
module windowed_sender_congestion_control_unit import wscc_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [SEG_W-1:0]     ack_id_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [SEG_W-1:0]     segment_id_o,
  output logic [WIN_W-1:0]     window_size_o,
  output logic [WIN_W-1:0]     threshold_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SEG_W-1:0]     cfg_data_i
);

  wscc_ctrl_t ctrl;
  wscc_stat_t stat;

  assign cfg_ready_o = 1'b1;

  wscc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  wscc_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .ack_id_i      (ack_id_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .segment_id_o  (segment_id_o),
    .window_size_o (window_size_o),
    .threshold_o   (threshold_o),
    .last_o        (last_o)
  );

endmodule

// ===== rtl/wscc_checker.sv =====
module wscc_checker import wscc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           kind_o,
  input logic [SEG_W-1:0]     segment_id_o,
  input logic [WIN_W-1:0]     window_size_o,
  input logic [WIN_W-1:0]     threshold_o,
  input logic                 last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segment_id_o) && $stable(kind_o)
      && $stable(window_size_o) && $stable(threshold_o) && $stable(last_o))
    else $error("order changed while stalled");

  a_fin_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_FIN || kind_o == KIND_FIN_RESEND)
      |-> segment_id_o == '0 && last_o)
    else $error("fin order malformed");

  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_size_o != '0 && window_size_o <= 6'd32)
    else $error("window size out of range");

  a_decode_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("event request taken without a decode cycle");

endmodule

bind windowed_sender_congestion_control_unit wscc_checker u_wscc_checker (.*);

// ===== verif/windowed_sender_congestion_control_unit_test.sv =====
module windowed_sender_congestion_control_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wscc_pkg::*;

  localparam int unsigned WIN_CAP      = (DEF_MAX_WINDOW < MARKS) ? DEF_MAX_WINDOW : MARKS;
  localparam int unsigned QUIET_CYCLES = 80;
  localparam int unsigned LIMIT_NS     = 4000000;
  localparam int unsigned PRESS_AT     = 40;
  localparam int unsigned PRESS_CYCLES = 300;

  typedef struct {
    logic [1:0]       kind;
    logic [SEG_W-1:0] seg;
    logic [WIN_W-1:0] win;
    logic [WIN_W-1:0] thr;
    logic             last;
  } order_t;

  class sender_scoreboard;
    int unsigned last_seg = LAST_SEG_RESET;
    int unsigned init_thr = THR_RESET;
    int unsigned base     = 0;
    int unsigned win      = 1;
    int unsigned thr      = THR_RESET;
    bit          marks [MARKS];
    int unsigned acked    = 0;
    int unsigned highest  = 0;
    bit          all_sent = 1'b0;
    bit          awaiting = 1'b0;
    bit          done     = 1'b0;
    order_t      orders [$];
    int unsigned errors   = 0;
    int unsigned checked  = 0;
    int unsigned events   = 0;
    int unsigned fins     = 0;
    int unsigned peak_win = 1;

    function bit idle();
      return highest == 0 && !all_sent && !awaiting && !done;
    endfunction

    function void clear_marks();
      foreach (marks[i]) marks[i] = 1'b0;
      acked = 0;
    endfunction

    function void add_order(logic [1:0] kind, int unsigned seg);
      order_t o;
      o.kind = kind;
      o.seg  = seg[SEG_W-1:0];
      o.win  = win[WIN_W-1:0];
      o.thr  = thr[WIN_W-1:0];
      o.last = 1'b0;
      orders.push_back(o);
      if (win > peak_win) peak_win = win;
      if (kind == KIND_FIN || kind == KIND_FIN_RESEND) fins++;
    endfunction

    function void send_window(bit resend);
      int unsigned seg_no;
      bit          final_seg;
      if (all_sent) return;
      for (int unsigned i = 0; i < win && i < MARKS; i++) begin
        seg_no    = (base + i + 1) & 16'hFFFF;
        final_seg = seg_no >= last_seg;
        if (final_seg) begin
          all_sent = 1'b1;
          win      = i + 1;
        end
        add_order((resend || seg_no <= highest) ? KIND_RESEND : KIND_SEND, seg_no);
        if (seg_no > highest) highest = seg_no;
        if (final_seg) break;
      end
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [SEG_W-1:0] data);
      if (idx == CFG_LAST_SEG) begin
        last_seg = data;
      end else begin
        init_thr = data[WIN_W-1:0];
        if (idle()) thr = init_thr;
      end
    endfunction

    function void note_event(cmd_e cmd, logic [SEG_W-1:0] ack_id);
      int unsigned ack;
      int unsigned first_order;
      int unsigned k;
      int unsigned adv;
      int unsigned w;
      ack         = ack_id;
      first_order = orders.size();
      events++;
      case (cmd)
        CMD_START: begin
          if (idle()) begin
            clear_marks();
            send_window(1'b0);
          end
        end
        CMD_ACK: begin
          if (!awaiting && !done && ack > base && ack - base <= win) begin
            k = (ack - base - 1) % MARKS;
            if (!marks[k]) begin
              marks[k] = 1'b1;
              acked++;
            end
            if (acked >= win) begin
              w    = win;
              base = (base + w) & 16'hFFFF;
              w    = (w < thr) ? w * 2 : w + 1;
              if (w > WIN_CAP) w = WIN_CAP;
              win = w;
              clear_marks();
              if (all_sent) begin
                awaiting = 1'b1;
                add_order(KIND_FIN, 0);
              end else begin
                send_window(1'b0);
              end
            end
          end
        end
        CMD_TIMEOUT: begin
          if (!done && awaiting) begin
            add_order(KIND_FIN_RESEND, 0);
          end else if (!done && highest != 0) begin
            adv = win;
            for (int unsigned i = 0; i < win && i < MARKS; i++) begin
              if (!marks[i]) begin
                adv = i;
                break;
              end
            end
            base = (base + adv) & 16'hFFFF;
            thr  = win / 2;
            if (thr < 1) thr = 1;
            win = 1;
            clear_marks();
            all_sent = 1'b0;
            send_window(1'b1);
          end
        end
        default: begin
          if (awaiting) begin
            awaiting = 1'b0;
            done     = 1'b1;
          end
        end
      endcase
      if (orders.size() > first_order) orders[orders.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [SEG_W-1:0] want, logic [SEG_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_order(logic [1:0] kind, logic [SEG_W-1:0] seg, logic [WIN_W-1:0] w,
                              logic [WIN_W-1:0] t, logic last);
      order_t want;
      checked++;
      if (orders.size() == 0) begin
        errors++;
        $display("%0t: order kind %0d segment %0d arrived with nothing expected",
                 $time, kind, seg);
        return;
      end
      want = orders.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("segment_id", want.seg, seg);
      compare_field("window_size", want.win, w);
      compare_field("threshold", want.thr, t);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  cmd_e                 cmd       = CMD_START;
  logic [SEG_W-1:0]     ack_id    = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LAST_SEG;
  logic [SEG_W-1:0]     cfg_data  = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           kind;
  logic [SEG_W-1:0]     segment_id;
  logic [WIN_W-1:0]     window_size;
  logic [WIN_W-1:0]     threshold;
  logic                 out_last;
  logic                 cfg_ready;

  sender_scoreboard sb = new();

  windowed_sender_congestion_control_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .ack_id_i      (ack_id),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .kind_o        (kind),
    .segment_id_o  (segment_id),
    .window_size_o (window_size),
    .threshold_o   (threshold),
    .last_o        (out_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic issue(cmd_e c, logic [SEG_W-1:0] a);
    int unsigned gap;
    in_valid <= 1'b1;
    cmd      <= c;
    ack_id   <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(c, a);
    gap = (((sb.events / 48) % 4) == 3) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SEG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.orders.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Mostly acks inside the current window, favouring segments not yet acked.
  task automatic pick_event(input bit timeouts, input bit fin_acks,
                            output cmd_e c, output logic [SEG_W-1:0] a);
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    a = 16'($urandom_range(0, 16'hFFFF));
    c = CMD_ACK;
    if (sb.done) begin
      c = cmd_e'(r[1:0]);
    end else if (sb.awaiting) begin
      if (r < 35) c = CMD_TIMEOUT;
      else if (r < 65 && fin_acks) c = CMD_FIN_ACK;
      else if (r < 80) c = CMD_START;
    end else if (r < 80) begin
      k = $urandom_range(0, sb.win - 1);
      if (sb.marks[k] && $urandom_range(0, 3) != 0) begin
        for (int unsigned j = 0; j < sb.win; j++) begin
          if (!sb.marks[(k + j) % sb.win]) begin
            k = (k + j) % sb.win;
            break;
          end
        end
      end
      a = 16'(sb.base + k + 1);
    end else if (r < 86 && timeouts) begin
      c = CMD_TIMEOUT;
    end else if (r < 90) begin
      a = 16'(sb.base + ((r % 2 == 0) ? 0 : sb.win + 1 + $urandom_range(0, 3)));
    end else if (r < 94) begin
      c = CMD_START;
    end else if (r < 97) begin
      c = CMD_FIN_ACK;
    end
  endtask

  initial begin
    int unsigned hold;
    int unsigned pressure;
    bit          pressed;
    hold     = 0;
    pressure = 0;
    pressed  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_order(kind, segment_id, window_size, threshold, out_last);
        hold = (((sb.checked / 64) % 3) == 2) ? 0 : $urandom_range(0, 5);
        if (sb.checked == PRESS_AT && !pressed) begin
          pressure = PRESS_CYCLES;
          pressed  = 1'b1;
        end
      end
      if (pressure > 0) begin
        pressure--;
        out_stall <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    cmd_e             c;
    logic [SEG_W-1:0] a;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Requests before the transfer has started, none of which should send anything.
    issue(CMD_TIMEOUT, 16'h0000);
    issue(CMD_FIN_ACK, 16'h0000);
    issue(CMD_ACK, 16'h0000);
    issue(CMD_ACK, 16'hFFFF);
    issue(CMD_ACK, 16'h0002);
    settle();
    write_reg(CFG_INIT_THR, 16'd1);
    write_reg(CFG_LAST_SEG, 16'hFFFF);
    write_reg(CFG_INIT_THR, 16'd32);

    issue(CMD_START, 16'($urandom_range(0, 16'hFFFF)));
    issue(CMD_START, 16'h0000);
    issue(CMD_ACK, 16'd1);
    issue(CMD_ACK, 16'd3);
    issue(CMD_ACK, 16'd3);
    issue(CMD_ACK, 16'd1);
    issue(CMD_ACK, 16'd8);
    issue(CMD_ACK, 16'd2);
    issue(CMD_ACK, 16'd7);
    issue(CMD_ACK, 16'd5);
    issue(CMD_ACK, 16'd4);
    issue(CMD_ACK, 16'd6);

    for (int n = 0; n < 130; n++) begin
      pick_event(1'b0, 1'b0, c, a);
      issue(c, a);
    end
    issue(CMD_TIMEOUT, 16'h0000);
    issue(CMD_TIMEOUT, 16'h0000);
    for (int n = 0; n < 120; n++) begin
      pick_event(1'b1, 1'b0, c, a);
      issue(c, a);
    end

    settle();
    write_reg(CFG_LAST_SEG, 16'(sb.highest + $urandom_range(20, 60)));
    for (int n = 0; n < 60; n++) begin
      pick_event(1'b1, 1'b0, c, a);
      issue(c, a);
    end

    settle();
    write_reg(CFG_LAST_SEG, 16'd1);
    write_reg(CFG_INIT_THR, 16'($urandom_range(2, 31)));
    for (int n = 0; n < 200 && !sb.done; n++) begin
      pick_event(1'b1, 1'b1, c, a);
      issue(c, a);
    end
    for (int n = 0; n < 20; n++) begin
      pick_event(1'b1, 1'b1, c, a);
      issue(c, a);
    end
    settle();

    $display("Sent %0d event requests and checked %0d orders, %0d of them fins.",
             sb.events, sb.checked, sb.fins);
    $display("Peak window %0d, transfer finished: %0d.", sb.peak_win, sb.done);
    if (sb.errors == 0) begin
      $display("windowed_sender_congestion_control_unit_test: clean");
    end else begin
      $display("windowed_sender_congestion_control_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("windowed_sender_congestion_control_unit_test: errors");
    $finish;
  end

endmodule
